>>> hw/rtl/lsr_pkg.sv
`default_nettype none

package lsr_pkg;

  localparam int unsigned FRAC_BITS_DEF = 12;
  localparam int unsigned VAL_W         = 16;
  localparam int unsigned STEP_W        = 12;
  localparam int unsigned PC_W          = 5;
  localparam int unsigned PADDR_W       = 2;
  localparam int unsigned PDATA_W       = 32;

  // Register map (byte addresses).
  localparam logic [PADDR_W-1:0] REG_STEP_SIZE = 2'd0;

  localparam logic [STEP_W-1:0] STEP_RESET  = 12'd41;
  localparam logic [VAL_W-1:0]  SPEED_RESET = 16'd4096;
  localparam logic [VAL_W-1:0]  LOW_RESET   = 16'd0;
  localparam logic [VAL_W-1:0]  HIGH_RESET  = 16'hFFFF;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_LIM,
    OP_FONE,
    OP_DIV,
    OP_MUL,
    OP_ACC_FIRST,
    OP_ACC_ADD,
    OP_WR_LO,
    OP_WR_HI,
    OP_CLAMP,
    OP_SPEED
  } op_e;

  typedef enum logic [2:0] {
    COND_NEXT,
    COND_ALWAYS,
    COND_NO_IN,
    COND_NO_BLEND,
    COND_FULL,
    COND_DIV_MORE,
    COND_OUT_BUSY
  } cond_e;

  typedef enum logic [1:0] {
    MSEL_PREV_LO,
    MSEL_CUR_LO,
    MSEL_PREV_HI,
    MSEL_CUR_HI
  } msel_e;

  typedef struct packed {
    op_e   op;
    msel_e msel;
  } ctrl_t;

  typedef struct packed {
    ctrl_t            ctrl;
    cond_e            cond;
    logic [PC_W-1:0]  target;
  } uword_t;

  typedef struct packed {
    logic in_valid;
    logic no_blend;
    logic full;
    logic div_more;
    logic out_busy;
  } flags_t;

  // Microprogram step addresses.
  localparam logic [PC_W-1:0] STEP_FETCH   = 5'd0;
  localparam logic [PC_W-1:0] STEP_LIMIT   = 5'd1;
  localparam logic [PC_W-1:0] STEP_FCHK    = 5'd2;
  localparam logic [PC_W-1:0] STEP_DIV     = 5'd3;
  localparam logic [PC_W-1:0] STEP_MUL_PL  = 5'd4;
  localparam logic [PC_W-1:0] STEP_ACC_L0  = 5'd5;
  localparam logic [PC_W-1:0] STEP_MUL_CL  = 5'd6;
  localparam logic [PC_W-1:0] STEP_ACC_L1  = 5'd7;
  localparam logic [PC_W-1:0] STEP_WR_LO   = 5'd8;
  localparam logic [PC_W-1:0] STEP_MUL_PH  = 5'd9;
  localparam logic [PC_W-1:0] STEP_ACC_H0  = 5'd10;
  localparam logic [PC_W-1:0] STEP_MUL_CH  = 5'd11;
  localparam logic [PC_W-1:0] STEP_ACC_H1  = 5'd12;
  localparam logic [PC_W-1:0] STEP_WR_HI   = 5'd13;
  localparam logic [PC_W-1:0] STEP_CLAMP   = 5'd14;
  localparam logic [PC_W-1:0] STEP_WAIT    = 5'd15;
  localparam logic [PC_W-1:0] STEP_SPEED   = 5'd16;

  function automatic uword_t lsr_rom(input logic [PC_W-1:0] pc);
    uword_t uw;
    uw = '{ctrl: '{op: OP_NOP, msel: MSEL_PREV_LO}, cond: COND_ALWAYS, target: STEP_FETCH};
    case (pc)
      STEP_FETCH:  uw = '{'{OP_LOAD,      MSEL_PREV_LO}, COND_NO_IN,    STEP_FETCH};
      STEP_LIMIT:  uw = '{'{OP_LIM,       MSEL_PREV_LO}, COND_NO_BLEND, STEP_CLAMP};
      STEP_FCHK:   uw = '{'{OP_FONE,      MSEL_PREV_LO}, COND_FULL,     STEP_MUL_PL};
      STEP_DIV:    uw = '{'{OP_DIV,       MSEL_PREV_LO}, COND_DIV_MORE, STEP_DIV};
      STEP_MUL_PL: uw = '{'{OP_MUL,       MSEL_PREV_LO}, COND_NEXT,     STEP_FETCH};
      STEP_ACC_L0: uw = '{'{OP_ACC_FIRST, MSEL_PREV_LO}, COND_NEXT,     STEP_FETCH};
      STEP_MUL_CL: uw = '{'{OP_MUL,       MSEL_CUR_LO},  COND_NEXT,     STEP_FETCH};
      STEP_ACC_L1: uw = '{'{OP_ACC_ADD,   MSEL_PREV_LO}, COND_NEXT,     STEP_FETCH};
      STEP_WR_LO:  uw = '{'{OP_WR_LO,     MSEL_PREV_LO}, COND_NEXT,     STEP_FETCH};
      STEP_MUL_PH: uw = '{'{OP_MUL,       MSEL_PREV_HI}, COND_NEXT,     STEP_FETCH};
      STEP_ACC_H0: uw = '{'{OP_ACC_FIRST, MSEL_PREV_LO}, COND_NEXT,     STEP_FETCH};
      STEP_MUL_CH: uw = '{'{OP_MUL,       MSEL_CUR_HI},  COND_NEXT,     STEP_FETCH};
      STEP_ACC_H1: uw = '{'{OP_ACC_ADD,   MSEL_PREV_LO}, COND_NEXT,     STEP_FETCH};
      STEP_WR_HI:  uw = '{'{OP_WR_HI,     MSEL_PREV_LO}, COND_NEXT,     STEP_FETCH};
      STEP_CLAMP:  uw = '{'{OP_CLAMP,     MSEL_PREV_LO}, COND_NEXT,     STEP_FETCH};
      STEP_WAIT:   uw = '{'{OP_NOP,       MSEL_PREV_LO}, COND_OUT_BUSY, STEP_WAIT};
      STEP_SPEED:  uw = '{'{OP_SPEED,     MSEL_PREV_LO}, COND_ALWAYS,   STEP_FETCH};
      default:     uw = '{'{OP_NOP,       MSEL_PREV_LO}, COND_ALWAYS,   STEP_FETCH};
    endcase
    return uw;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/lsr_seq.sv
`default_nettype none

module lsr_seq (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire lsr_pkg::flags_t flags_i,
  output lsr_pkg::ctrl_t      ctrl_o,
  output logic                fetch_o
);
  import lsr_pkg::*;

  logic [PC_W-1:0] pc_q, pc_d;
  uword_t          uw;
  logic            take;

  assign uw = lsr_rom(pc_q);

  always_comb begin
    case (uw.cond)
      COND_NEXT:     take = 1'b0;
      COND_ALWAYS:   take = 1'b1;
      COND_NO_IN:    take = ~flags_i.in_valid;
      COND_NO_BLEND: take = flags_i.no_blend;
      COND_FULL:     take = flags_i.full;
      COND_DIV_MORE: take = flags_i.div_more;
      COND_OUT_BUSY: take = flags_i.out_busy;
      default:       take = 1'b1;
    endcase
    pc_d = take ? uw.target : pc_q + PC_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= STEP_FETCH;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign ctrl_o  = uw.ctrl;
  assign fetch_o = (pc_q == STEP_FETCH);

endmodule

`default_nettype wire

>>> hw/rtl/limited_speed_ramp_top.sv
`default_nettype none
// Channel  | Handshake                 | Payload
// ---------+---------------------------+--------------------------------------------
// input    | in_valid_i / in_stall_o   | set_target_i .. cur_high_limit_i (one tick)
// output   | out_valid_o / out_stall_i | speed_now_o, target_now_o, *_limit_now_o
// config   | APB (psel .. pready)      | step_size at byte address 0
//
// A tick skips the blend when none is needed, takes a factor of one when the
// overlap factor saturates and otherwise works the factor out in the
// bit-serial divider, which produces one quotient bit per cycle.
// Reset is asynchronous and active low; it returns the speed and target to one,
// the limits to full range and step_size to 41.
// A finished result sits in the output register while the next transaction is
// taken; the sequencer only waits on a stalled output when its own result is ready.

module limited_speed_ramp_top #(
  parameter int unsigned FRAC_BITS = lsr_pkg::FRAC_BITS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // Input channel
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic                         set_target_i,
  input  wire logic [lsr_pkg::VAL_W-1:0]    requested_target_i,
  input  wire logic                         motion_active_i,
  input  wire logic                         in_overlap_i,
  input  wire logic [lsr_pkg::VAL_W-1:0]    blend_time_i,
  input  wire logic [lsr_pkg::VAL_W-1:0]    blend_length_i,
  input  wire logic [lsr_pkg::VAL_W-1:0]    prev_low_limit_i,
  input  wire logic [lsr_pkg::VAL_W-1:0]    prev_high_limit_i,
  input  wire logic [lsr_pkg::VAL_W-1:0]    cur_low_limit_i,
  input  wire logic [lsr_pkg::VAL_W-1:0]    cur_high_limit_i,
  // Output channel
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic [lsr_pkg::VAL_W-1:0]         speed_now_o,
  output logic [lsr_pkg::VAL_W-1:0]         target_now_o,
  output logic [lsr_pkg::VAL_W-1:0]         low_limit_now_o,
  output logic [lsr_pkg::VAL_W-1:0]         high_limit_now_o,
  // Configuration port
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [lsr_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [lsr_pkg::PDATA_W-1:0]  pwdata,
  output logic [lsr_pkg::PDATA_W-1:0]       prdata,
  output logic                              pready
);
  import lsr_pkg::*;

  localparam int unsigned F_W   = FRAC_BITS + 1;
  localparam int unsigned ACC_W = VAL_W + FRAC_BITS + 1;
  localparam int unsigned CNT_W = $clog2(FRAC_BITS + 1);
  localparam logic [F_W-1:0]   F_ONE = F_W'(1) << FRAC_BITS;
  localparam logic [ACC_W-1:0] HALF  = ACC_W'(1) << (FRAC_BITS - 1);

  // Configuration register. Writes must arrive only while the block is idle; the block does not enforce it.
  logic [STEP_W-1:0] step_q;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr == REG_STEP_SIZE);
  assign prdata = (paddr == REG_STEP_SIZE) ? PDATA_W'(step_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_RESET;
    end else if (cfg_wr) begin
      step_q <= pwdata[STEP_W-1:0];
    end
  end

  // The sequencer owns the step counter and the microprogram; everything below
  // is the plain datapath that its control word drives.
  ctrl_t  ctrl;
  flags_t flags;
  logic   fetch;
  logic   in_acc;

  lsr_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .ctrl_o  (ctrl),
    .fetch_o (fetch)
  );

  assign in_stall_o = ~fetch;
  assign in_acc     = in_valid_i && fetch;

  // Captured transaction.
  logic             set_q, active_q, overlap_q;
  logic [VAL_W-1:0] req_q, time_q, len_q, plo_q, phi_q, clo_q, chi_q;

  // Divider, multiplier and accumulator.
  logic [F_W-1:0]   f_q;
  logic [VAL_W-1:0] rem_q;
  logic [CNT_W-1:0] cnt_q;
  logic [ACC_W-1:0] prod_q, acc_q;

  // Architectural state.
  logic [VAL_W-1:0] speed_q, tgt_q, lo_q, hi_q;

  // Output register.
  logic             out_valid_q;
  logic [VAL_W-1:0] out_speed_q, out_tgt_q, out_lo_q, out_hi_q;

  logic out_busy;
  assign out_busy = out_valid_q && out_stall_i;

  assign flags.in_valid = in_valid_i;
  assign flags.no_blend = ~(active_q && overlap_q);
  assign flags.full     = (len_q == '0) || (time_q >= len_q);
  assign flags.div_more = (cnt_q != CNT_W'(1));
  assign flags.out_busy = out_busy;

  // One restoring division step: the partial remainder is always below the
  // divisor, so the shifted value fits in one extra bit.
  logic [VAL_W:0]   rem_sh;
  logic             q_bit;
  logic [VAL_W-1:0] rem_nx;

  always_comb begin
    rem_sh = {rem_q, 1'b0};
    q_bit  = (rem_sh >= {1'b0, len_q});
    rem_nx = q_bit ? VAL_W'(rem_sh - {1'b0, len_q}) : rem_sh[VAL_W-1:0];
  end

  // Multiplier operands: previous limits weigh with (one - f), current with f.
  logic [VAL_W-1:0] mul_a;
  logic [F_W-1:0]   mul_b;

  always_comb begin
    case (ctrl.msel)
      MSEL_PREV_LO: begin
        mul_a = plo_q;
        mul_b = F_ONE - f_q;
      end
      MSEL_CUR_LO: begin
        mul_a = clo_q;
        mul_b = f_q;
      end
      MSEL_PREV_HI: begin
        mul_a = phi_q;
        mul_b = F_ONE - f_q;
      end
      MSEL_CUR_HI: begin
        mul_a = chi_q;
        mul_b = f_q;
      end
      default: begin
        mul_a = plo_q;
        mul_b = f_q;
      end
    endcase
  end

  // Target clamp: raise to the low limit first, then the high limit wins.
  logic [VAL_W-1:0] tgt_raw, tgt_lo, tgt_cl;

  always_comb begin
    tgt_raw = set_q ? req_q : tgt_q;
    tgt_lo  = (tgt_raw < lo_q) ? lo_q : tgt_raw;
    tgt_cl  = (tgt_lo > hi_q) ? hi_q : tgt_lo;
  end

  // Slew step toward the target without overshoot.
  logic [VAL_W-1:0] step_ext, spd_nx;

  always_comb begin
    step_ext = VAL_W'(step_q);
    spd_nx   = speed_q;
    if (speed_q < tgt_q) begin
      spd_nx = ((tgt_q - speed_q) > step_ext) ? speed_q + step_ext : tgt_q;
    end else if (speed_q > tgt_q) begin
      spd_nx = ((speed_q - tgt_q) > step_ext) ? speed_q - step_ext : tgt_q;
    end
  end

  // Payload registers without reset.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      set_q     <= set_target_i;
      req_q     <= requested_target_i;
      active_q  <= motion_active_i;
      overlap_q <= in_overlap_i;
      time_q    <= blend_time_i;
      len_q     <= blend_length_i;
      plo_q     <= prev_low_limit_i;
      phi_q     <= prev_high_limit_i;
      clo_q     <= cur_low_limit_i;
      chi_q     <= cur_high_limit_i;
    end
    case (ctrl.op)
      OP_LIM: begin
        rem_q <= time_q;
        cnt_q <= CNT_W'(FRAC_BITS);
        f_q   <= '0;
      end
      OP_FONE:      f_q    <= F_ONE;
      OP_DIV: begin
        rem_q <= rem_nx;
        cnt_q <= cnt_q - CNT_W'(1);
        f_q   <= {f_q[F_W-2:0], q_bit};
      end
      OP_MUL:       prod_q <= ACC_W'(mul_a) * ACC_W'(mul_b);
      OP_ACC_FIRST: acc_q  <= prod_q + HALF;
      OP_ACC_ADD:   acc_q  <= acc_q + prod_q;
      OP_SPEED: begin
        out_speed_q <= spd_nx;
        out_tgt_q   <= tgt_q;
        out_lo_q    <= lo_q;
        out_hi_q    <= hi_q;
      end
      default: begin
      end
    endcase
  end

  // State registers and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_q     <= SPEED_RESET;
      tgt_q       <= SPEED_RESET;
      lo_q        <= LOW_RESET;
      hi_q        <= HIGH_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (ctrl.op == OP_SPEED) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (ctrl.op)
        OP_LIM: begin
          if (active_q && !overlap_q) begin
            lo_q <= clo_q;
            hi_q <= chi_q;
          end
        end
        OP_WR_LO: lo_q  <= acc_q[FRAC_BITS +: VAL_W];
        OP_WR_HI: hi_q  <= acc_q[FRAC_BITS +: VAL_W];
        OP_CLAMP: tgt_q <= tgt_cl;
        OP_SPEED: speed_q <= spd_nx;
        default: begin
        end
      endcase
    end
  end

  assign out_valid_o      = out_valid_q;
  assign speed_now_o      = out_speed_q;
  assign target_now_o     = out_tgt_q;
  assign low_limit_now_o  = out_lo_q;
  assign high_limit_now_o = out_hi_q;

`ifndef SYNTH
  // With consistent limits the reported target lies between them.
  a_target_in_limits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (low_limit_now_o <= high_limit_now_o)) |->
    ((target_now_o >= low_limit_now_o) && (target_now_o <= high_limit_now_o)))
    else $error("reported target outside the limits in force");

  // An accepted transaction keeps the input side stalled on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken again before the tick was worked");

  // Without a transaction the speed does not move.
  a_speed_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fetch && !in_valid_i) |=> $stable(speed_q))
    else $error("speed changed while no tick was in progress");
`endif

endmodule

`default_nettype wire

>>> bench/tb_limited_speed_ramp_top.sv
`default_nettype none

// Bench for the limited speed ramp. Ticks are queued by the stimulus process,
// presented by a driver at the falling edge and accepted at the rising edge.
// Every accepted tick is run through a local model of the ramp, and the result
// it gives is queued. The monitor pops that queue whenever the block hands over
// a result, and it compares the result field by field.
module tb_limited_speed_ramp_top;
  import lsr_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 1000000;
  // Leaves a comfortable margin over the longest tick.
  localparam int unsigned SETTLE_CYCLES = 60;
  localparam int unsigned LONG_HOLD     = 300;
  localparam int unsigned MAX_PRINTED   = 40;

  // One tick as offered on the input channel.
  typedef struct packed {
    logic             set_target;
    logic [VAL_W-1:0] req_target;
    logic             active;
    logic             overlap;
    logic [VAL_W-1:0] btime;
    logic [VAL_W-1:0] blen;
    logic [VAL_W-1:0] prev_lo;
    logic [VAL_W-1:0] prev_hi;
    logic [VAL_W-1:0] cur_lo;
    logic [VAL_W-1:0] cur_hi;
  } tick_t;

  // One result as handed over on the output channel.
  typedef struct packed {
    logic [VAL_W-1:0] speed;
    logic [VAL_W-1:0] target;
    logic [VAL_W-1:0] lo;
    logic [VAL_W-1:0] hi;
  } ramp_out_t;

  // Every input of the block starts at a known value.
  logic               clk_i              = 1'b0;
  logic               rst_ni             = 1'b0;
  logic               in_valid_i         = 1'b0;
  logic               set_target_i       = 1'b0;
  logic [VAL_W-1:0]   requested_target_i = '0;
  logic               motion_active_i    = 1'b0;
  logic               in_overlap_i       = 1'b0;
  logic [VAL_W-1:0]   blend_time_i       = '0;
  logic [VAL_W-1:0]   blend_length_i     = '0;
  logic [VAL_W-1:0]   prev_low_limit_i   = '0;
  logic [VAL_W-1:0]   prev_high_limit_i  = '0;
  logic [VAL_W-1:0]   cur_low_limit_i    = '0;
  logic [VAL_W-1:0]   cur_high_limit_i   = '0;
  logic               out_stall_i        = 1'b0;
  logic               psel               = 1'b0;
  logic               penable            = 1'b0;
  logic               pwrite             = 1'b0;
  logic [PADDR_W-1:0] paddr              = '0;
  logic [PDATA_W-1:0] pwdata             = '0;

  logic               in_stall_o;
  logic               out_valid_o;
  logic [VAL_W-1:0]   speed_now_o;
  logic [VAL_W-1:0]   target_now_o;
  logic [VAL_W-1:0]   low_limit_now_o;
  logic [VAL_W-1:0]   high_limit_now_o;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  limited_speed_ramp_top DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .set_target_i       (set_target_i),
    .requested_target_i (requested_target_i),
    .motion_active_i    (motion_active_i),
    .in_overlap_i       (in_overlap_i),
    .blend_time_i       (blend_time_i),
    .blend_length_i     (blend_length_i),
    .prev_low_limit_i   (prev_low_limit_i),
    .prev_high_limit_i  (prev_high_limit_i),
    .cur_low_limit_i    (cur_low_limit_i),
    .cur_high_limit_i   (cur_high_limit_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .speed_now_o        (speed_now_o),
    .target_now_o       (target_now_o),
    .low_limit_now_o    (low_limit_now_o),
    .high_limit_now_o   (high_limit_now_o),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Local copy of the ramp state and of the step size register.
  logic [VAL_W-1:0]  ramp_speed;
  logic [VAL_W-1:0]  ramp_target;
  logic [VAL_W-1:0]  ramp_low;
  logic [VAL_W-1:0]  ramp_high;
  logic [STEP_W-1:0] ramp_step;

  tick_t     ticks_pending_q[$];
  ramp_out_t ramp_results_q[$];
  tick_t     drv_tick = '0;

  int unsigned ticks_offered  = 0;
  int unsigned ticks_taken    = 0;
  int unsigned results_seen   = 0;
  int unsigned mismatches     = 0;
  int unsigned cycle_cnt      = 0;
  int unsigned gap_left       = 0;
  int unsigned stall_left     = 0;
  int unsigned hold_left      = 0;
  bit          long_hold_done = 1'b0;

  // Idling rates in percent per opportunity, and the shape of random ticks;
  // the stimulus process changes them from one phase to the next.
  int unsigned gap_pct   = 0;
  int unsigned stall_pct = 0;
  bit          steady    = 1'b0;

  task automatic report_mismatch(input string msg);
    if (mismatches < MAX_PRINTED) begin
      $display("ERROR at cycle %0d: %s", cycle_cnt, msg);
    end
    mismatches++;
  endtask

  // Mostly short idle stretches, with the odd long one.
  function automatic int unsigned idle_length();
    if ($urandom_range(0, 9) == 0) begin
      return $urandom_range(10, 60);
    end
    return $urandom_range(1, 3);
  endfunction

  // Linear blend in Q4.12, rounded to nearest with halves rounded up.
  function automatic logic [VAL_W-1:0] blend_limit(input logic [VAL_W-1:0] from,
                                                   input logic [VAL_W-1:0] to,
                                                   input longint unsigned  f);
    longint unsigned one;
    longint unsigned acc;
    one = 64'd1 << FRAC_BITS_DEF;
    acc = from * (one - f) + to * f + (one >> 1);
    return VAL_W'(acc >> FRAC_BITS_DEF);
  endfunction

  // Works out one tick of the ramp and updates the local state.
  function automatic ramp_out_t advance_ramp(input tick_t t);
    ramp_out_t       r;
    longint unsigned one;
    longint unsigned f;
    logic [VAL_W-1:0] lo;
    logic [VAL_W-1:0] hi;
    logic [VAL_W-1:0] tgt;
    logic [VAL_W-1:0] spd;
    logic [VAL_W-1:0] stp;
    one = 64'd1 << FRAC_BITS_DEF;
    if (t.active && t.overlap) begin
      // A zero overlap length counts as a fully blended factor.
      f = one;
      if (t.blen != 0) begin
        f = {48'd0, t.btime};
        f = (f << FRAC_BITS_DEF) / {48'd0, t.blen};
        if (f > one) begin
          f = one;
        end
      end
      lo = blend_limit(t.prev_lo, t.cur_lo, f);
      hi = blend_limit(t.prev_hi, t.cur_hi, f);
    end else if (t.active) begin
      lo = t.cur_lo;
      hi = t.cur_hi;
    end else begin
      // Without a motion the overlap flag is ignored and the limits stay.
      lo = ramp_low;
      hi = ramp_high;
    end
    tgt = t.set_target ? t.req_target : ramp_target;
    // The low clamp comes first, so an inverted pair lets the high limit win.
    if (tgt < lo) begin
      tgt = lo;
    end
    if (tgt > hi) begin
      tgt = hi;
    end
    stp = VAL_W'(ramp_step);
    spd = ramp_speed;
    if (spd < tgt) begin
      spd = (tgt - spd > stp) ? spd + stp : tgt;
    end else if (spd > tgt) begin
      spd = (spd - tgt > stp) ? spd - stp : tgt;
    end
    ramp_speed  = spd;
    ramp_target = tgt;
    ramp_low    = lo;
    ramp_high   = hi;
    r.speed  = ramp_speed;
    r.target = ramp_target;
    r.lo     = ramp_low;
    r.hi     = ramp_high;
    return r;
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return VAL_W'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  // Random tick. Limit pairs are mostly ordered and blend times mostly fall
  // inside the overlap, so that blending ticks mostly take the divider path.
  // In steady mode motions and new targets are rare, which lets the speed
  // settle on its target.
  function automatic tick_t random_tick();
    tick_t            t;
    logic [VAL_W-1:0] a;
    logic [VAL_W-1:0] b;
    t.set_target = steady ? ($urandom_range(0, 7) == 0) : ($urandom_range(0, 1) != 0);
    t.req_target = pick_value();
    t.active     = steady ? ($urandom_range(0, 7) == 0) : ($urandom_range(0, 3) != 0);
    t.overlap    = ($urandom_range(0, 1) != 0);
    a = pick_value();
    b = pick_value();
    if (a > b && $urandom_range(0, 4) != 0) begin
      t.prev_lo = b;
      t.prev_hi = a;
    end else begin
      t.prev_lo = a;
      t.prev_hi = b;
    end
    a = pick_value();
    b = pick_value();
    if (a > b && $urandom_range(0, 4) != 0) begin
      t.cur_lo = b;
      t.cur_hi = a;
    end else begin
      t.cur_lo = a;
      t.cur_hi = b;
    end
    t.blen  = ($urandom_range(0, 9) == 0) ? '0 : pick_value();
    t.btime = ($urandom_range(0, 5) == 0) ? pick_value()
                                          : VAL_W'($urandom_range(0, t.blen));
    return t;
  endfunction

  task automatic queue_tick(input logic st, input logic [VAL_W-1:0] req,
                            input logic act, input logic ovl,
                            input logic [VAL_W-1:0] bt, input logic [VAL_W-1:0] bl,
                            input logic [VAL_W-1:0] plo, input logic [VAL_W-1:0] phi,
                            input logic [VAL_W-1:0] clo, input logic [VAL_W-1:0] chi);
    tick_t t;
    t = '{st, req, act, ovl, bt, bl, plo, phi, clo, chi};
    ticks_pending_q.push_back(t);
  endtask

  task automatic queue_random(input int unsigned n);
    repeat (n) begin
      ticks_pending_q.push_back(random_tick());
    end
  endtask

  // Holds the sender back until every queued tick has been taken and every
  // expected result has come, then lets the block settle.
  task automatic drain();
    while (ticks_pending_q.size() != 0 || in_valid_i || ramp_results_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Writes step_size over the configuration port and reads it back. Only
  // called while the block is idle. Upper data bits may carry junk, which the
  // register has to ignore.
  task automatic write_step(input logic [STEP_W-1:0] val, input bit junk);
    logic [PDATA_W-1:0] data;
    logic [PDATA_W-1:0] rd;
    data = junk ? $urandom : '0;
    data[STEP_W-1:0] = val;
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_STEP_SIZE;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    ramp_step = val;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    psel    <= 1'b1;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rd = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd !== {{(PDATA_W-STEP_W){1'b0}}, val}) begin
      report_mismatch($sformatf("step_size read back %0h, expected %0h", rd, val));
    end
  endtask

  // Input driver. A tick stays on the port until it is accepted; after that
  // the next one follows at once or after a random gap. The valid line gets
  // exactly one assignment per falling edge.
  always @(negedge clk_i) begin : drive_ticks
    logic nxt_valid;
    nxt_valid = in_valid_i;
    if (in_valid_i && ticks_taken == ticks_offered) begin
      nxt_valid = 1'b0;
    end
    if (!nxt_valid) begin
      if (gap_left != 0) begin
        gap_left--;
      end else if (ticks_pending_q.size() != 0) begin
        drv_tick           = ticks_pending_q.pop_front();
        set_target_i       <= drv_tick.set_target;
        requested_target_i <= drv_tick.req_target;
        motion_active_i    <= drv_tick.active;
        in_overlap_i       <= drv_tick.overlap;
        blend_time_i       <= drv_tick.btime;
        blend_length_i     <= drv_tick.blen;
        prev_low_limit_i   <= drv_tick.prev_lo;
        prev_high_limit_i  <= drv_tick.prev_hi;
        cur_low_limit_i    <= drv_tick.cur_lo;
        cur_high_limit_i   <= drv_tick.cur_hi;
        nxt_valid = 1'b1;
        ticks_offered++;
        gap_left = ($urandom_range(0, 99) < gap_pct) ? idle_length() : 0;
      end
    end
    in_valid_i <= nxt_valid;
  end

  // Output stall. Once in the run the receiver holds off for a long stretch
  // while plenty of ticks are still queued, so that the block backs up and
  // stalls its input; otherwise it stalls at random.
  always @(negedge clk_i) begin : drive_stall
    if (!long_hold_done && results_seen >= 100 && ticks_pending_q.size() > 50) begin
      long_hold_done = 1'b1;
      hold_left      = LONG_HOLD;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
      if ($urandom_range(0, 99) < stall_pct) begin
        stall_left = idle_length();
      end
    end
  end

  // Sampling at the rising edge. The result handed over at this edge is
  // checked before the tick accepted at the same edge is predicted, so the
  // outcome does not depend on process order.
  always @(posedge clk_i) begin : sample
    ramp_out_t got;
    ramp_out_t want;
    cycle_cnt++;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got = '{speed_now_o, target_now_o, low_limit_now_o, high_limit_now_o};
        results_seen++;
        if (ramp_results_q.size() == 0) begin
          report_mismatch("result transaction with nothing expected");
        end else begin
          want = ramp_results_q.pop_front();
          if (got.speed !== want.speed) begin
            report_mismatch($sformatf("speed_now %0d, expected %0d", got.speed, want.speed));
          end
          if (got.target !== want.target) begin
            report_mismatch($sformatf("target_now %0d, expected %0d",
                                      got.target, want.target));
          end
          if (got.lo !== want.lo) begin
            report_mismatch($sformatf("low_limit_now %0d, expected %0d", got.lo, want.lo));
          end
          if (got.hi !== want.hi) begin
            report_mismatch($sformatf("high_limit_now %0d, expected %0d", got.hi, want.hi));
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        ramp_results_q.push_back(advance_ramp(drv_tick));
        ticks_taken++;
      end
    end
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin : watchdog
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
    end
    $display("limited_speed_ramp_top: mismatch");
    $finish;
  end

  initial begin : stimulus
    ramp_speed  = SPEED_RESET;
    ramp_target = SPEED_RESET;
    ramp_low    = LOW_RESET;
    ramp_high   = HIGH_RESET;
    ramp_step   = STEP_RESET;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed ticks with the reset step size. The speed starts at one.
    gap_pct   = 30;
    stall_pct = 30;
    // No motion at all: the reset limits stay in force.
    queue_tick(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    // A target within one step is reached exactly, a far one by a full step.
    queue_tick(1, 16'd4100, 0, 0, 0, 0, 0, 0, 0, 0);
    queue_tick(1, 16'd4000, 0, 0, 0, 0, 0, 0, 0, 0);
    queue_tick(1, 16'hFFFF, 0, 0, 0, 0, 0, 0, 0, 0);
    // Overlap flagged without an active motion is ignored.
    queue_tick(1, 16'd0, 0, 1, 16'd100, 16'd200, 16'd1000, 16'd2000, 16'd3000, 16'd4000);
    // Motion limits taken as they are, full range.
    queue_tick(0, 0, 1, 0, '1, '1, '1, '1, 16'h0000, 16'hFFFF);
    // Low limit above high limit: the high limit wins.
    queue_tick(1, 16'h8000, 1, 0, 0, 0, 0, 0, 16'h9000, 16'h2000);
    // Zero overlap length: the current motion's limits.
    queue_tick(1, 16'd5000, 1, 1, 16'd1234, 16'd0, 16'd100, 16'd200, 16'd300, 16'd400);
    // Blend time far beyond the overlap: the factor saturates.
    queue_tick(1, 16'd5000, 1, 1, 16'hFFFF, 16'd1, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000);
    // Start of the overlap: the previous motion's limits.
    queue_tick(1, 16'd5000, 1, 1, 16'd0, 16'd100, 16'd1000, 16'd9000, 16'd3000, 16'd7000);
    // Half way with odd sums, so that halves are rounded up.
    queue_tick(1, 16'd100, 1, 1, 16'd1, 16'd2, 16'd1, 16'd3, 16'd0, 16'd0);
    // Largest values just short of the end of the overlap.
    queue_tick(1, '1, 1, 1, 16'd65534, 16'hFFFF, '1, '1, '1, '1);
    // A typical blend through the divider.
    queue_tick(0, 0, 1, 1, 16'd12345, 16'd54321, 16'h0100, 16'hF000, 16'h4000, 16'h8000);
    // Blend time equal to the overlap length.
    queue_tick(1, 16'd30000, 1, 1, 16'd777, 16'd777, 16'h0000, 16'h0000, '1, '1);
    // Requested target below the low limit and above the high limit.
    queue_tick(1, 16'h0010, 1, 0, 0, 0, 0, 0, 16'h2000, 16'h3000);
    queue_tick(1, 16'hF000, 1, 0, 0, 0, 0, 0, 16'h1000, 16'h1800);
    // Stored target kept while a request is offered but not loaded.
    queue_tick(0, '1, 0, 0, 0, 0, 0, 0, 0, 0);
    // Blend from an inverted previous pair.
    queue_tick(1, 16'h5555, 1, 1, 16'd300, 16'd900, 16'hAAAA, 16'h5555, 16'h1111, 16'hEEEE);
    queue_tick(1, '1, 1, 1, '1, '1, '1, '1, '1, '1);
    queue_tick(0, 0, 0, 1, '1, 0, 0, 0, 0, 0);
    drain();

    // Random phases. The long receiver hold-off falls in the first one.
    gap_pct   = 5;
    stall_pct = 20;
    steady    = 1'b0;
    queue_random(250);
    drain();

    // Zero step: the speed must not move. No idling on either side.
    write_step('0, 1'b0);
    gap_pct   = 0;
    stall_pct = 0;
    queue_random(150);
    drain();

    // Largest step with settling targets, so that exact arrival is common.
    write_step('1, 1'b0);
    gap_pct   = 30;
    stall_pct = 30;
    steady    = 1'b1;
    queue_random(250);
    drain();

    write_step(12'd1, 1'b1);
    gap_pct   = 50;
    stall_pct = 50;
    steady    = 1'b0;
    queue_random(150);
    drain();

    write_step(STEP_W'($urandom_range(2, 4094)), 1'b0);
    gap_pct   = 20;
    stall_pct = 40;
    queue_random(250);
    drain();

    write_step(STEP_RESET, 1'b1);
    gap_pct   = 10;
    stall_pct = 10;
    steady    = 1'b1;
    queue_random(200);
    drain();

    write_step(STEP_W'($urandom_range(0, 4095)), 1'b1);
    gap_pct   = 40;
    stall_pct = 10;
    steady    = 1'b0;
    queue_random(150);
    drain();

    if (mismatches == 0) begin
      $display("limited_speed_ramp_top: match");
    end else begin
      $display("limited_speed_ramp_top: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire
